/* hdl/mau_pkg.sv */
// Shared types and constants of the modular arithmetic unit.
package mau_pkg;

  localparam int unsigned MODE_W    = 3;
  localparam int unsigned OPND_W    = 64;
  localparam int unsigned RES_W     = 31;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned RED_CNT_W = 6;

  localparam logic [PDATA_W-1:0] MOD_RESET = 32'd998244353;
  localparam logic [PADDR_W-1:0] ADDR_MODULUS = 3'd0;

  typedef enum logic [MODE_W-1:0] {
    OP_REDUCE,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW,
    OP_INV,
    OP_NEG
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_DISPATCH,
    ST_POW_STEP,
    ST_MUL_R,
    ST_MUL_X,
    ST_FIN_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

/* hdl/mau_if.sv */
// Valid/ready channel interfaces for operation items and results.
interface mau_in_if import mau_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [OPND_W-1:0] operand_a;
  logic signed [OPND_W-1:0] operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface mau_out_if import mau_pkg::*;;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result;
  logic             bad_exponent;

  modport source (output valid, result, bad_exponent, input ready);
  modport sink (input valid, result, bad_exponent, output ready);
endinterface

/* hdl/mau_mulmod.sv */
// Bit-serial modular multiplier: each multiplier bit takes a doubling phase and then an add phase.
module mau_mulmod import mau_pkg::*; #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MOD_BITS-1:0] x_i,
  input  logic [MOD_BITS-1:0] y_i,
  input  logic [MOD_BITS-1:0] mod_i,
  output mul_stat_t           stat_o,
  output logic [MOD_BITS-1:0] prod_o
);

  localparam int unsigned CNT_W = $clog2(MOD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_BITS - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic                phase_q, phase_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [MOD_BITS-1:0] x_q, x_d;
  logic [MOD_BITS-1:0] y_q, y_d;
  logic [MOD_BITS-1:0] acc_q, acc_d;
  logic [MOD_BITS:0]   dbl, dbl_red, sum, sum_red, mod_ext;

  // Horner form, most significant multiplier bit first: acc = 2*acc (+ x).
  always_comb begin
    mod_ext = {1'b0, mod_i};
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
    sum     = {1'b0, acc_q} + {1'b0, x_q};
    sum_red = (sum >= mod_ext) ? sum - mod_ext : sum;
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      cnt_d   = '0;
      x_d     = x_i;
      y_d     = y_i;
      acc_d   = '0;
    end else if (busy_q) begin
      if (!phase_q) begin
        acc_d   = dbl_red[MOD_BITS-1:0];
        phase_d = 1'b1;
      end else begin
        if (y_q[MOD_BITS-1]) begin
          acc_d = sum_red[MOD_BITS-1:0];
        end
        y_d     = {y_q[MOD_BITS-2:0], 1'b0};
        phase_d = 1'b0;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

/* hdl/modular_arithmetic_unit_top.sv */
// Modular arithmetic unit: reduce, add, subtract, multiply, divide, power, inverse, negate.
// Each item is handled alone. Both operands are first reduced bit-serially, one bit a
// cycle, and then dispatched; reduce, add, subtract and negate finish at dispatch.
// Every modular product goes through a shared bit-serial multiplier. Power performs up
// to two products for each bit of the exponent (at most 63 bits), inverse up to two for
// each bit of modulus-2, and divide an inverse plus one final product. A finished
// result waits in the output register while the next item is taken. The modulus is
// written over the APB port at byte address 0 and must only change while the unit is idle.
module modular_arithmetic_unit_top import mau_pkg::*; #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mau_in_if.sink             in_if,
  mau_out_if.source          out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [RED_CNT_W-1:0] RED_LAST = '1;
  localparam logic [MOD_BITS-1:0]  MOD_ONE  = MOD_BITS'(1);
  localparam logic [MOD_BITS-1:0]  MOD_TWO  = MOD_BITS'(2);

  state_e                state_q, state_d;
  op_e                   mode_q, mode_d;
  logic [MOD_BITS-1:0]   mod_q;
  logic [OPND_W-1:0]     braw_q, braw_d;
  logic [OPND_W-1:0]     mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [RED_CNT_W-1:0]  cnt_q, cnt_d;
  logic [MOD_BITS-1:0]   red_q, red_d;
  logic [MOD_BITS-1:0]   a_q, a_d, b_q, b_d;
  logic [MOD_BITS-1:0]   base_q, base_d, acc_q, acc_d;
  logic [OPND_W-1:0]     exp_q, exp_d;
  logic [MOD_BITS-1:0]   res_q, res_d;
  logic                  bad_q, bad_d;
  logic                  out_valid_q, out_valid_d;
  logic [MOD_BITS-1:0]   out_res_q, out_res_d;
  logic                  out_bad_q, out_bad_d;

  logic                  in_fire, cfg_we;
  logic [MOD_BITS:0]     mod_ext, red_t, red_step_w, add_w, sub_w;
  logic [MOD_BITS-1:0]   red_step, red_fix;
  logic [OPND_W-1:0]     mod_m2;
  logic                  mul_start;
  logic [MOD_BITS-1:0]   mul_x, mul_y, mul_prod;
  mul_stat_t             mul_stat;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == ADDR_MODULUS);
  assign prdata = (paddr == ADDR_MODULUS) ? PDATA_W'(mod_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MOD_RESET[MOD_BITS-1:0];
    end else if (cfg_we) begin
      mod_q <= pwdata[MOD_BITS-1:0];
    end
  end

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;

  // One bit of the magnitude enters the running remainder each cycle.
  always_comb begin
    mod_ext    = {1'b0, mod_q};
    red_t      = {red_q, mag_q[OPND_W-1]};
    red_step_w = (red_t >= mod_ext) ? red_t - mod_ext : red_t;
    red_step   = red_step_w[MOD_BITS-1:0];
    red_fix    = (neg_q && (red_step != '0)) ? mod_q - red_step : red_step;
    add_w      = {1'b0, a_q} + {1'b0, b_q};
    sub_w      = {1'b0, a_q} - {1'b0, b_q};
    mod_m2     = OPND_W'(mod_q - MOD_TWO);
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    braw_d      = braw_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    red_d       = red_q;
    a_d         = a_q;
    b_d         = b_q;
    base_d      = base_q;
    acc_d       = acc_q;
    exp_d       = exp_q;
    res_d       = res_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_res_d   = out_res_q;
    out_bad_d   = out_bad_q;
    mul_start   = 1'b0;
    mul_x       = acc_q;
    mul_y       = base_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mode_d = op_e'(in_if.mode);
          braw_d = in_if.operand_b;
          neg_d  = in_if.operand_a[OPND_W-1];
          mag_d  = in_if.operand_a[OPND_W-1] ? OPND_W'(0) - in_if.operand_a
                                             : in_if.operand_a;
          red_d  = '0;
          cnt_d  = '0;
          res_d  = '0;
          bad_d  = (op_e'(in_if.mode) == OP_POW) && in_if.operand_b[OPND_W-1];
          if (bad_d || (mod_q < MOD_TWO)) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_RED_A;
          end
        end
      end
      ST_RED_A: begin
        red_d = red_step;
        mag_d = {mag_q[OPND_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RED_LAST) begin
          a_d     = red_fix;
          neg_d   = braw_q[OPND_W-1];
          mag_d   = braw_q[OPND_W-1] ? OPND_W'(0) - braw_q : braw_q;
          red_d   = '0;
          state_d = ST_RED_B;
        end
      end
      ST_RED_B: begin
        red_d = red_step;
        mag_d = {mag_q[OPND_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RED_LAST) begin
          b_d     = red_fix;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        acc_d   = MOD_ONE;
        state_d = ST_OUT;
        case (mode_q)
          OP_REDUCE: res_d = a_q;
          OP_ADD: begin
            res_d = (add_w >= mod_ext) ? MOD_BITS'(add_w - mod_ext) : add_w[MOD_BITS-1:0];
          end
          OP_SUB: begin
            res_d = sub_w[MOD_BITS] ? MOD_BITS'(sub_w + mod_ext) : sub_w[MOD_BITS-1:0];
          end
          OP_MUL: begin
            mul_start = 1'b1;
            mul_x     = a_q;
            mul_y     = b_q;
            state_d   = ST_FIN_MUL;
          end
          OP_DIV: begin
            base_d = b_q;
            exp_d  = mod_m2;
            if (b_q != '0) begin
              state_d = ST_POW_STEP;
            end
          end
          OP_POW: begin
            base_d = a_q;
            exp_d  = braw_q;
            if (a_q != '0) begin
              state_d = ST_POW_STEP;
            end
          end
          OP_INV: begin
            base_d = a_q;
            exp_d  = mod_m2;
            if (a_q != '0) begin
              state_d = ST_POW_STEP;
            end
          end
          OP_NEG: res_d = (a_q == '0) ? '0 : mod_q - a_q;
          default: res_d = '0;
        endcase
      end
      ST_POW_STEP: begin
        // Square-and-multiply from the low exponent bit upward.
        mul_start = 1'b1;
        if (exp_q == '0) begin
          if (mode_q == OP_DIV) begin
            mul_x   = acc_q;
            mul_y   = a_q;
            state_d = ST_FIN_MUL;
          end else begin
            mul_start = 1'b0;
            res_d     = acc_q;
            state_d   = ST_OUT;
          end
        end else if (exp_q[0]) begin
          mul_x   = acc_q;
          mul_y   = base_q;
          state_d = ST_MUL_R;
        end else begin
          mul_x   = base_q;
          mul_y   = base_q;
          state_d = ST_MUL_X;
        end
      end
      ST_MUL_R: begin
        if (mul_stat.done) begin
          acc_d = mul_prod;
          if (exp_q[OPND_W-1:1] == '0) begin
            // The last exponent bit needs no further squaring.
            exp_d   = '0;
            state_d = ST_POW_STEP;
          end else begin
            mul_start = 1'b1;
            mul_x     = base_q;
            mul_y     = base_q;
            state_d   = ST_MUL_X;
          end
        end
      end
      ST_MUL_X: begin
        if (mul_stat.done) begin
          base_d  = mul_prod;
          exp_d   = {1'b0, exp_q[OPND_W-1:1]};
          state_d = ST_POW_STEP;
        end
      end
      ST_FIN_MUL: begin
        if (mul_stat.done) begin
          res_d   = mul_prod;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_bad_d   = bad_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    braw_q    <= braw_d;
    mag_q     <= mag_d;
    neg_q     <= neg_d;
    cnt_q     <= cnt_d;
    red_q     <= red_d;
    a_q       <= a_d;
    b_q       <= b_d;
    base_q    <= base_d;
    acc_q     <= acc_d;
    exp_q     <= exp_d;
    res_q     <= res_d;
    bad_q     <= bad_d;
    out_res_q <= out_res_d;
    out_bad_q <= out_bad_d;
  end

  mau_mulmod #(
    .MOD_BITS (MOD_BITS)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .mod_i   (mod_q),
    .stat_o  (mul_stat),
    .prod_o  (mul_prod)
  );

  assign out_if.valid        = out_valid_q;
  assign out_if.result       = RES_W'(out_res_q);
  assign out_if.bad_exponent = out_bad_q;

`ifndef SYNTHESIS
  a_res_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_res_q < mod_q) || (out_res_q == '0)))
    else $error("result not below the modulus");

  a_bad_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> (out_res_q == '0))
    else $error("bad exponent with nonzero result");

  a_mul_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> ((state_q == ST_MUL_R) || (state_q == ST_MUL_X) ||
                       (state_q == ST_FIN_MUL)))
    else $error("multiplier finished with nobody waiting");

  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("accepted transfer did not start work");
`endif

endmodule

/* bench/tb.sv */
// Self-checking testbench for the modular arithmetic unit, with random handshakes.
module tb import mau_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MOD_BITS = 31;
  localparam int unsigned N_DIR = 27;

  localparam logic [OPND_W-1:0] I64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [OPND_W-1:0] I64_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [OPND_W-1:0] I64_NEG1 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [OPND_W-1:0] I64_NEG5 = 64'hFFFF_FFFF_FFFF_FFFB;

  typedef struct packed {
    logic [RES_W-1:0] result;
    logic             bad_exponent;
  } residue_t;

  typedef enum logic {ROW_ITEM, ROW_MODULUS} row_kind_e;

  // For modulus rows, operand a holds the value to write.
  typedef struct packed {
    row_kind_e         kind;
    op_e               op;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic              typed;
    residue_t          want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic [MOD_BITS-1:0] mod_cfg;
  logic [31:0]         rdy_pattern;
  residue_t            pending_residues [$];
  residue_t            head_r;
  int                  mismatch_cnt = 0;

  mau_in_if  in_if ();
  mau_out_if out_if ();

  modular_arithmetic_unit_top #(
    .MOD_BITS(MOD_BITS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Directed items: extremes, every operation, and the special cases.
  // Expected values are typed in only where they follow at a glance.
  dir_row_t dir_tbl [N_DIR] = '{
    '{ROW_ITEM, OP_REDUCE, 64'd0, 64'd0, 1'b1, '{31'd0, 1'b0}},
    '{ROW_ITEM, OP_REDUCE, I64_MAX, 64'd0, 1'b0, '{31'd0, 1'b0}},
    '{ROW_ITEM, OP_REDUCE, I64_MIN, I64_NEG1, 1'b0, '{31'd0, 1'b0}},
    '{ROW_ITEM, OP_REDUCE, I64_NEG1, 64'd0, 1'b1, '{31'd998244352, 1'b0}},
    '{ROW_ITEM, OP_ADD, 64'd998244352, 64'd1, 1'b1, '{31'd0, 1'b0}},
    '{ROW_ITEM, OP_ADD, I64_NEG1, I64_NEG1, 1'b1, '{31'd998244351, 1'b0}},
    '{ROW_ITEM, OP_SUB, 64'd0, 64'd1, 1'b1, '{31'd998244352, 1'b0}},
    '{ROW_ITEM, OP_MUL, I64_NEG1, I64_NEG1, 1'b1, '{31'd1, 1'b0}},
    '{ROW_ITEM, OP_MUL, I64_MAX, I64_MIN, 1'b0, '{31'd0, 1'b0}},
    '{ROW_ITEM, OP_DIV, 64'd6, 64'd3, 1'b1, '{31'd2, 1'b0}},
    '{ROW_ITEM, OP_DIV, 64'd7, 64'd0, 1'b1, '{31'd0, 1'b0}},
    '{ROW_ITEM, OP_POW, 64'd0, 64'd0, 1'b1, '{31'd0, 1'b0}},
    '{ROW_ITEM, OP_POW, 64'd5, 64'd0, 1'b1, '{31'd1, 1'b0}},
    '{ROW_ITEM, OP_POW, 64'd3, I64_NEG1, 1'b1, '{31'd0, 1'b1}},
    '{ROW_ITEM, OP_POW, I64_NEG1, I64_MAX, 1'b1, '{31'd998244352, 1'b0}},
    '{ROW_ITEM, OP_INV, 64'd0, 64'd0, 1'b1, '{31'd0, 1'b0}},
    '{ROW_ITEM, OP_INV, 64'd2, 64'd0, 1'b1, '{31'd499122177, 1'b0}},
    '{ROW_ITEM, OP_NEG, 64'd1, 64'd0, 1'b1, '{31'd998244352, 1'b0}},
    '{ROW_MODULUS, OP_REDUCE, 64'd1, 64'd0, 1'b0, '{31'd0, 1'b0}},
    '{ROW_ITEM, OP_POW, 64'd2, I64_NEG5, 1'b1, '{31'd0, 1'b1}},
    '{ROW_ITEM, OP_ADD, 64'd3, 64'd4, 1'b1, '{31'd0, 1'b0}},
    '{ROW_MODULUS, OP_REDUCE, 64'h8000_0007, 64'd0, 1'b0, '{31'd0, 1'b0}},
    '{ROW_ITEM, OP_INV, 64'd3, 64'd0, 1'b1, '{31'd5, 1'b0}},
    '{ROW_ITEM, OP_MUL, I64_NEG1, I64_MAX, 1'b0, '{31'd0, 1'b0}},
    '{ROW_MODULUS, OP_REDUCE, 64'd10, 64'd0, 1'b0, '{31'd0, 1'b0}},
    '{ROW_ITEM, OP_INV, 64'd3, 64'd0, 1'b1, '{31'd1, 1'b0}},
    '{ROW_ITEM, OP_INV, 64'd2, 64'd0, 1'b1, '{31'd6, 1'b0}}
  };

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Two's complement value folded into [0, m).
  function automatic longint unsigned fold(input logic [OPND_W-1:0] raw,
                                           input longint unsigned m);
    longint unsigned r;
    if (raw[OPND_W-1]) begin
      r = (64'd0 - raw) % m;
      if (r != 0) r = m - r;
    end else begin
      r = raw % m;
    end
    return r;
  endfunction

  // Square-and-multiply; a zero base gives zero even for a zero exponent.
  function automatic longint unsigned pow_residue(input longint unsigned x,
                                                  input logic [OPND_W-1:0] y,
                                                  input longint unsigned m);
    longint unsigned r;
    r = 1;
    if (x == 0) return 0;
    while (y != 0) begin
      if (y[0]) r = (r * x) % m;
      x = (x * x) % m;
      y = y >> 1;
    end
    return r % m;
  endfunction

  function automatic residue_t eval_residue(input op_e op, input logic [OPND_W-1:0] a_raw,
                                            input logic [OPND_W-1:0] b_raw);
    longint unsigned m, a, b, r;
    residue_t res;
    m = mod_cfg;
    r = 0;
    res.bad_exponent = (op == OP_POW) && b_raw[OPND_W-1];
    if (m >= 2 && !res.bad_exponent) begin
      a = fold(a_raw, m);
      b = fold(b_raw, m);
      case (op)
        OP_REDUCE: r = a;
        OP_ADD:    r = (a + b) % m;
        OP_SUB:    r = (a + m - b) % m;
        OP_MUL:    r = (a * b) % m;
        OP_DIV:    r = (a * pow_residue(b, m - 2, m)) % m;
        OP_POW:    r = pow_residue(a, b_raw, m);
        OP_INV:    r = pow_residue(a, m - 2, m);
        default:   r = (m - a) % m;
      endcase
    end
    res.result = r[RES_W-1:0];
    return res;
  endfunction

  function automatic logic [OPND_W-1:0] pick_operand();
    longint unsigned m, k;
    logic [OPND_W-1:0] v;
    m = mod_cfg;
    k = $urandom_range(0, 5);
    case ($urandom_range(0, 9))
      0, 1, 2: v = {$urandom, $urandom};
      3:       v = 64'($urandom_range(0, 40));
      4:       v = 64'd0 - 64'($urandom_range(1, 40));
      5:       v = m * k + 64'($urandom_range(0, 2)) - 64'd1;
      6:       v = 64'd0 - m * k;
      7:       v = I64_MIN;
      8:       v = I64_MAX;
      default: v = 64'($urandom_range(0, 32'h7FFF_FFFF));
    endcase
    return v;
  endfunction

  // Mostly short exponents keep the run fast; a few use all 63 bits.
  function automatic logic [OPND_W-1:0] pick_exponent();
    logic [OPND_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0, 1:    v[OPND_W-1] = 1'b1;
      2:       v[OPND_W-1] = 1'b0;
      3:       v = 64'd0;
      4, 5:    v = 64'($urandom_range(1, 3));
      default: v = 64'($urandom_range(1, 4000));
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  // Valid stays high after the transfer; the caller lowers it for a gap.
  task automatic send_item(input op_e op, input logic [OPND_W-1:0] a,
                           input logic [OPND_W-1:0] b, input logic typed,
                           input residue_t want);
    in_if.valid     <= 1'b1;
    in_if.mode      <= op;
    in_if.operand_a <= a;
    in_if.operand_b <= b;
    do @(posedge clk_i); while (!in_if.ready);
    pending_residues.push_back(typed ? want : eval_residue(op, a, b));
  endtask

  task automatic drain_results();
    while (pending_residues.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_MODULUS;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_modulus(input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b1, value, rd);
    mod_cfg = value[MOD_BITS-1:0];
    // A wait with psel low keeps the two transfers apart.
    @(posedge clk_i);
    apb_xfer(1'b0, '0, rd);
    if (rd !== PDATA_W'(mod_cfg)) report_mismatch("modulus readback", rd, PDATA_W'(mod_cfg));
  endtask

  task automatic run_random(input logic [PDATA_W-1:0] mod_val, input int n_items);
    int left, burst;
    logic bursty;
    op_e op;
    logic [OPND_W-1:0] a, b;
    drain_results();
    set_modulus(mod_val);
    rdy_pattern <= ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h1);
    bursty = ($urandom_range(0, 3) != 0);
    left = n_items;
    while (left > 0) begin
      burst = bursty ? $urandom_range(1, 6) : left;
      if (burst > left) burst = left;
      repeat (burst) begin
        op = op_e'($urandom_range(0, 7));
        a = pick_operand();
        b = (op == OP_POW) ? pick_exponent() : pick_operand();
        send_item(op, a, b, 1'b0, '0);
        left--;
      end
      in_if.valid <= 1'b0;
      // Occasional long gaps let the next item arrive at any stage of the work.
      if (left > 0) begin
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8))
          @(posedge clk_i);
      end
    end
  endtask

  // Receiver: ready follows a rotating stall pattern that changes per phase.
  initial begin
    int unsigned rdy_idx;
    rdy_idx = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= rdy_pattern[rdy_idx % 32];
      rdy_idx++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_residues.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(out_if.result), 32'd0);
      end else begin
        head_r = pending_residues.pop_front();
        if (out_if.result !== head_r.result)
          report_mismatch("result", 32'(out_if.result), 32'(head_r.result));
        if (out_if.bad_exponent !== head_r.bad_exponent)
          report_mismatch("bad_exponent", 32'(out_if.bad_exponent),
                          32'(head_r.bad_exponent));
      end
    end
  end

  initial begin
    logic [PDATA_W-1:0] rd;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.mode      <= OP_REDUCE;
    in_if.operand_a <= '0;
    in_if.operand_b <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    rdy_pattern     <= 32'hFFFF_FFFF;
    mod_cfg = MOD_RESET[MOD_BITS-1:0];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_xfer(1'b0, '0, rd);
    if (rd !== PDATA_W'(mod_cfg)) report_mismatch("modulus after reset", rd, PDATA_W'(mod_cfg));

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_MODULUS) begin
        in_if.valid <= 1'b0;
        drain_results();
        set_modulus(dir_tbl[i].a[PDATA_W-1:0]);
      end else begin
        send_item(dir_tbl[i].op, dir_tbl[i].a, dir_tbl[i].b, dir_tbl[i].typed,
                  dir_tbl[i].want);
      end
    end
    in_if.valid <= 1'b0;

    run_random(32'd2147483647, 30);
    run_random(32'd2, 12);
    run_random(32'd0, 6);
    // All 32 bits random: exercises the truncated write and non-prime moduli.
    run_random($urandom, 20);
    run_random(32'd65521, 20);
    run_random(MOD_RESET, 28);

    drain_results();
    // Long enough for a stray result from the slowest operation to show up.
    repeat (9000) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("modular_arithmetic_unit_top test passed");
    end else begin
      $display("modular_arithmetic_unit_top test failed");
    end
    $finish;
  end

  initial begin
    #150ms;
    $display("modular_arithmetic_unit_top test failed");
    $finish;
  end

endmodule
